// ===== rtl/ctt_pkg.sv =====
// ----------------------------------------------------------------------------
// ctt_pkg: shared types and constants for the config text tokenizer
// Lexer modes, event and error codes, the result word and character codes.
// ----------------------------------------------------------------------------
package ctt_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDLE_HASH,
    MODE_ATOM,
    MODE_ATOM_ESC,
    MODE_ATOM_HASH,
    MODE_QD,
    MODE_QD_ESC,
    MODE_QS,
    MODE_SKIP,
    MODE_NL_PEND
  } lex_mode_e;

  typedef enum logic [2:0] {
    EV_BYTE,
    EV_WEND,
    EV_NL,
    EV_OPEN,
    EV_CLOSE,
    EV_END,
    EV_ERR
  } event_kind_e;

  typedef enum logic [1:0] {
    ERR_BAD_CHAR,
    ERR_ESC_EOL,
    ERR_OPEN_DQ,
    ERR_OPEN_SQ
  } err_code_e;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [7:0] MAX_ERRORS_RESET = 8'd16;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  typedef struct packed {
    event_kind_e kind;
    logic [7:0]  char_value;
    err_code_e   code;
    logic [31:0] off;
    logic [31:0] len;
    logic        ok;
    logic        trunc;
    logic        last;
  } tok_res_t;

  // up to two results per source word
  typedef struct packed {
    logic [1:0] cnt;
    tok_res_t   r1;
    tok_res_t   r0;
  } lex_out_t;

  function automatic tok_res_t mk_res(event_kind_e kind, logic [7:0] chv, err_code_e code,
                                      logic [31:0] off, logic [31:0] len);
    tok_res_t r;
    r.kind       = kind;
    r.char_value = chv;
    r.code       = code;
    r.off        = off;
    r.len        = len;
    r.ok         = 1'b0;
    r.trunc      = 1'b0;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/ctt_in_if.sv =====
// ----------------------------------------------------------------------------
// ctt_in_if: source byte channel
// Valid/ready channel carrying one source byte or an end-of-source mark.
// ----------------------------------------------------------------------------
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, output ch, output end_of_source, input ready);
  modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

// ===== rtl/ctt_out_if.sv =====
// ----------------------------------------------------------------------------
// ctt_out_if: token event channel
// Valid/ready channel carrying one token event word.
// ----------------------------------------------------------------------------
interface ctt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  char_value;
  logic [1:0]  error_code;
  logic [31:0] span_offset;
  logic [31:0] span_length;
  logic        source_ok;
  logic        errors_truncated;
  logic        last_event;

  modport source (output valid, output event_kind, output char_value, output error_code,
                  output span_offset, output span_length, output source_ok,
                  output errors_truncated, output last_event, input ready);
  modport sink   (input valid, input event_kind, input char_value, input error_code,
                  input span_offset, input span_length, input source_ok,
                  input errors_truncated, input last_event, output ready);
endinterface

// ===== rtl/ctt_lexer.sv =====
// ----------------------------------------------------------------------------
// ctt_lexer: tokenizer state and per-byte decode
// Holds mode, position, token start and error counters; decodes one source
// word into up to two result words.
// ----------------------------------------------------------------------------
module ctt_lexer #(
  parameter int OFFSET_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        ch_i,
  input  logic              eos_i,
  input  logic [7:0]        max_errors_i,
  output ctt_pkg::lex_out_t res_o
);
  import ctt_pkg::*;

  localparam logic [OFFSET_BITS-1:0] ONE = OFFSET_BITS'(1);

  lex_mode_e              mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] ts_q, ts_d;
  logic [7:0]             errs_q, errs_d;
  logic                   trunc_q, trunc_d;

  logic [OFFSET_BITS-1:0] prev;
  logic [OFFSET_BITS-1:0] pos_nx;
  logic                   is_ws, is_nl, is_brk;
  logic                   do_idle, do_atom, err_hit;
  logic [1:0]             n;
  tok_res_t               r [2];

  // low 32 bits of an offset, zero-extended for narrow offsets
  function automatic logic [31:0] span32(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+31:0] e;
    e = {32'b0, v};
    return e[31:0];
  endfunction

  assign prev   = pos_q - ONE;
  assign pos_nx = pos_q + ONE;
  assign is_ws  = (ch_i == CH_SPACE) || (ch_i == CH_TAB);
  assign is_nl  = (ch_i == CH_NL);
  assign is_brk = is_nl || (ch_i == CH_SEMI);

  always_comb begin
    mode_d  = mode_q;
    pos_d   = pos_q;
    ts_d    = ts_q;
    errs_d  = errs_q;
    trunc_d = trunc_q;
    do_idle = 1'b0;
    do_atom = 1'b0;
    err_hit = 1'b0;
    n       = 2'd0;
    r[0]    = '0;
    r[1]    = '0;

    if (eos_i) begin
      unique case (mode_q)
        MODE_ATOM: begin
          r[n[0]] = mk_res(EV_WEND, 8'd0, ERR_BAD_CHAR, span32(ts_q), span32(pos_q - ts_q));
          n = n + 2'd1;
        end
        MODE_ATOM_ESC: begin
          r[n[0]] = mk_res(EV_ERR, 8'd0, ERR_ESC_EOL, span32(prev), 32'd1);
          n = n + 2'd1;
          err_hit = 1'b1;
        end
        MODE_ATOM_HASH: begin
          r[n[0]] = mk_res(EV_WEND, 8'd0, ERR_BAD_CHAR, span32(ts_q), span32(prev - ts_q));
          n = n + 2'd1;
        end
        MODE_QD, MODE_QD_ESC: begin
          r[n[0]] = mk_res(EV_ERR, 8'd0, ERR_OPEN_DQ, span32(ts_q), 32'd1);
          n = n + 2'd1;
          err_hit = 1'b1;
        end
        MODE_QS: begin
          r[n[0]] = mk_res(EV_ERR, 8'd0, ERR_OPEN_SQ, span32(ts_q), 32'd1);
          n = n + 2'd1;
          err_hit = 1'b1;
        end
        MODE_NL_PEND: begin
          r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(ts_q), 32'd1);
          n = n + 2'd1;
        end
        default: ;
      endcase
    end else begin
      pos_d = pos_nx;
      unique case (mode_q)
        MODE_IDLE_HASH: begin
          if (is_ws) begin
            mode_d = MODE_SKIP;
          end else if (is_nl) begin
            r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            r[n[0]] = mk_res(EV_BYTE, CH_HASH, ERR_BAD_CHAR, 32'd0, 32'd0);
            n = n + 2'd1;
            do_atom = 1'b1;
          end
        end
        MODE_ATOM: begin
          do_atom = 1'b1;
        end
        MODE_ATOM_ESC: begin
          if (is_nl) begin
            r[n[0]] = mk_res(EV_ERR, 8'd0, ERR_ESC_EOL, span32(prev), 32'd1);
            n = n + 2'd1;
            err_hit = 1'b1;
            r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            r[n[0]] = mk_res(EV_BYTE, ch_i, ERR_BAD_CHAR, 32'd0, 32'd0);
            n = n + 2'd1;
            mode_d = MODE_ATOM;
          end
        end
        MODE_ATOM_HASH: begin
          if (is_ws) begin
            r[n[0]] = mk_res(EV_WEND, 8'd0, ERR_BAD_CHAR, span32(ts_q), span32(prev - ts_q));
            n = n + 2'd1;
            mode_d = MODE_SKIP;
          end else if (is_nl) begin
            r[n[0]] = mk_res(EV_WEND, 8'd0, ERR_BAD_CHAR, span32(ts_q), span32(prev - ts_q));
            n = n + 2'd1;
            r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            r[n[0]] = mk_res(EV_BYTE, CH_HASH, ERR_BAD_CHAR, 32'd0, 32'd0);
            n = n + 2'd1;
            do_atom = 1'b1;
          end
        end
        MODE_QD: begin
          if (is_nl) begin
            r[n[0]] = mk_res(EV_ERR, 8'd0, ERR_OPEN_DQ, span32(ts_q), 32'd1);
            n = n + 2'd1;
            err_hit = 1'b1;
            r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else if (ch_i == CH_DQUOTE) begin
            r[n[0]] = mk_res(EV_WEND, 8'd0, ERR_BAD_CHAR, span32(ts_q), span32(pos_nx - ts_q));
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else if (ch_i == CH_BSLASH) begin
            mode_d = MODE_QD_ESC;
          end else begin
            r[n[0]] = mk_res(EV_BYTE, ch_i, ERR_BAD_CHAR, 32'd0, 32'd0);
            n = n + 2'd1;
          end
        end
        MODE_QD_ESC: begin
          if (is_nl) begin
            r[n[0]] = mk_res(EV_ERR, 8'd0, ERR_OPEN_DQ, span32(ts_q), 32'd1);
            n = n + 2'd1;
            err_hit = 1'b1;
            r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            r[n[0]] = mk_res(EV_BYTE, ch_i, ERR_BAD_CHAR, 32'd0, 32'd0);
            n = n + 2'd1;
            mode_d = MODE_QD;
          end
        end
        MODE_QS: begin
          if (is_nl) begin
            r[n[0]] = mk_res(EV_ERR, 8'd0, ERR_OPEN_SQ, span32(ts_q), 32'd1);
            n = n + 2'd1;
            err_hit = 1'b1;
            r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else if (ch_i == CH_SQUOTE) begin
            r[n[0]] = mk_res(EV_WEND, 8'd0, ERR_BAD_CHAR, span32(ts_q), span32(pos_nx - ts_q));
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            r[n[0]] = mk_res(EV_BYTE, ch_i, ERR_BAD_CHAR, 32'd0, 32'd0);
            n = n + 2'd1;
          end
        end
        MODE_SKIP: begin
          if (is_nl) begin
            r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_NL_PEND: begin
          // flush the newline held back from the previous word
          r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(ts_q), 32'd1);
          n = n + 2'd1;
          do_idle = 1'b1;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // byte between tokens
      if (do_idle) begin
        mode_d = MODE_IDLE;
        if (is_ws) begin
          mode_d = MODE_IDLE;
        end else if (is_brk) begin
          r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
          n = n + 2'd1;
        end else if (ch_i == CH_LBRACE) begin
          r[n[0]] = mk_res(EV_OPEN, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
          n = n + 2'd1;
        end else if (ch_i == CH_RBRACE) begin
          r[n[0]] = mk_res(EV_CLOSE, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
          n = n + 2'd1;
        end else if (ch_i == CH_HASH) begin
          ts_d   = pos_q;
          mode_d = MODE_IDLE_HASH;
        end else if (ch_i == CH_DQUOTE) begin
          ts_d   = pos_q;
          mode_d = MODE_QD;
        end else if (ch_i == CH_SQUOTE) begin
          ts_d   = pos_q;
          mode_d = MODE_QS;
        end else begin
          ts_d    = pos_q;
          do_atom = 1'b1;
        end
      end

      // byte inside a bare word
      if (do_atom) begin
        if (is_ws) begin
          r[n[0]] = mk_res(EV_WEND, 8'd0, ERR_BAD_CHAR, span32(ts_d), span32(pos_q - ts_d));
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end else if (is_brk) begin
          r[n[0]] = mk_res(EV_WEND, 8'd0, ERR_BAD_CHAR, span32(ts_d), span32(pos_q - ts_d));
          n = n + 2'd1;
          if (n < 2'd2) begin
            r[n[0]] = mk_res(EV_NL, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            // no room for the newline: hold it for the next word
            ts_d   = pos_q;
            mode_d = MODE_NL_PEND;
          end
        end else if (ch_i == CH_HASH) begin
          mode_d = MODE_ATOM_HASH;
        end else if ((ch_i == CH_DQUOTE) || (ch_i == CH_SQUOTE) ||
                     (ch_i == CH_LBRACE) || (ch_i == CH_RBRACE)) begin
          r[n[0]] = mk_res(EV_ERR, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd1);
          n = n + 2'd1;
          err_hit = 1'b1;
          mode_d = MODE_SKIP;
        end else if (ch_i == CH_BSLASH) begin
          mode_d = MODE_ATOM_ESC;
        end else begin
          r[n[0]] = mk_res(EV_BYTE, ch_i, ERR_BAD_CHAR, 32'd0, 32'd0);
          n = n + 2'd1;
          mode_d = MODE_ATOM;
        end
      end
    end

    // count errors up to the limit, flag truncation past it
    if (err_hit) begin
      if (errs_q < max_errors_i) begin
        errs_d = errs_q + 8'd1;
      end else begin
        trunc_d = 1'b1;
      end
    end

    if (eos_i) begin
      r[n[0]] = mk_res(EV_END, 8'd0, ERR_BAD_CHAR, span32(pos_q), 32'd0);
      r[n[0]].ok    = (errs_d == 8'd0) && !trunc_d;
      r[n[0]].trunc = trunc_d;
      n = n + 2'd1;
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      ts_d    = '0;
      errs_d  = '0;
      trunc_d = 1'b0;
    end

    if (n == 2'd1) begin
      r[0].last = 1'b1;
    end else if (n == 2'd2) begin
      r[1].last = 1'b1;
    end
  end

  assign res_o.cnt = n;
  assign res_o.r0  = r[0];
  assign res_o.r1  = r[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      ts_q    <= '0;
      errs_q  <= '0;
      trunc_q <= 1'b0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      ts_q    <= ts_d;
      errs_q  <= errs_d;
      trunc_q <= trunc_d;
    end
  end

endmodule

// ===== rtl/ctt_res_fifo.sv =====
// ----------------------------------------------------------------------------
// ctt_res_fifo: result word queue
// Four-entry queue taking up to two result words per cycle, giving one.
// ----------------------------------------------------------------------------
module ctt_res_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  ctt_pkg::lex_out_t              data_i,
  input  logic                           pop_i,
  output ctt_pkg::tok_res_t              head_o,
  output logic [ctt_pkg::RES_CNT_W-1:0]  count_o
);
  import ctt_pkg::*;

  tok_res_t               mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [RES_CNT_W-1:0]   count_q, count_d;
  logic [1:0]             push_n;

  assign push_n  = push_i ? data_i.cnt : 2'd0;
  assign wp_d    = wp_q + RES_PTR_W'(push_n);
  assign rp_d    = rp_q + RES_PTR_W'(pop_i);
  assign count_d = count_q + RES_CNT_W'(push_n) - RES_CNT_W'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wp_q] <= data_i.r0;
    end
    if (push_n == 2'd2) begin
      mem_q[wp_q + RES_PTR_W'(1)] <= data_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  assign head_o  = mem_q[rp_q];
  assign count_o = count_q;

endmodule

// ===== rtl/config_text_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// config_text_tokenizer_unit: streaming tokenizer for brace-structured config
// Splits a byte stream into word bytes, word ends, newlines, braces, errors
// and an end event, one source word per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// A source word (one byte or an end-of-source mark) is taken into an input
// register, decoded combinationally against the lexer mode, and its event
// words, at most two, go into a four-entry result queue that feeds the output
// port. The input takes one word per cycle while the queue has room for two
// event words; the output gives one event word per cycle while the receiver
// is ready, so a byte that causes two events (word end and newline, an error
// and newline, a flushed word and the end) takes two output transfers, and
// the steady rate is set by how many events the text produces. Bytes between
// tokens and inside comments produce no event word at all. Offsets count in
// OFFSET_BITS and show their low 32 bits; the end event resets position and
// error counters for the next source, while max_errors keeps its value.
// Write max_errors only while the block is idle.
module config_text_tokenizer_unit #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  ctt_in_if.sink      in_i,
  ctt_out_if.source   out_o
);
  import ctt_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           in_ch_q;
  logic                 in_eos_q;
  logic [7:0]           max_errors_q;
  logic                 fire;
  logic                 pop;
  logic [RES_CNT_W-1:0] fifo_count;
  lex_out_t             lex_res;
  tok_res_t             head;

  // advance the lexer only when the queue can take two event words
  assign fire      = in_valid_q && (fifo_count <= RES_CNT_W'(RES_DEPTH - 2));
  assign in_i.ready = !in_valid_q || fire;

  // max_errors register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_errors_q <= MAX_ERRORS_RESET;
    end else if (cfg_we_i) begin
      max_errors_q <= cfg_wdata_i;
    end
  end

  // input register: hold the word until the lexer consumes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_ch_q  <= in_i.ch;
      in_eos_q <= in_i.end_of_source;
    end
  end

  ctt_lexer #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lexer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .ch_i         (in_ch_q),
    .eos_i        (in_eos_q),
    .max_errors_i (max_errors_q),
    .res_o        (lex_res)
  );

  ctt_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .data_i  (lex_res),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count)
  );

  // drive the output port from the queue head
  assign pop                    = out_o.valid && out_o.ready;
  assign out_o.valid            = (fifo_count != '0);
  assign out_o.event_kind       = head.kind;
  assign out_o.char_value       = head.char_value;
  assign out_o.error_code       = head.code;
  assign out_o.span_offset      = head.off;
  assign out_o.span_length      = head.len;
  assign out_o.source_ok        = head.ok;
  assign out_o.errors_truncated = head.trunc;
  assign out_o.last_event       = head.last;

`ifndef ASSERT_OFF
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overfilled");

  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_eos_q) |-> (lex_res.cnt != 2'd0))
    else $error("end of source produced no event");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.event_kind == EV_END)) |-> out_o.last_event)
    else $error("end event not marked last");
`endif

endmodule
